### sv/ilsc_pkg.sv
package ilsc_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int PROD_WIDTH  = VALUE_WIDTH + 4;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_ZERO   = 3'b010,
      PH_DIGITS = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      RK_DEC = 2'd0,
      RK_HEX = 2'd1,
      RK_OCT = 2'd2,
      RK_BIN = 2'd3
   } radix_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_RANGE     = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_BAD_START = 2'd3
   } error_type;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_UPPER_B = 8'h42;

   localparam logic [4:0] NOT_DIGIT  = 5'd16;

   typedef struct packed {
      logic [7:0] ch;
      logic       first;
   } req_item_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      radix_type              radix_kind;
      error_type              error_code;
   } scan_result_type;

   // digit value 0..15, or 16 for a non-digit
   function automatic logic [4:0] digit_of(input logic [7:0] c);
      logic [4:0] d;
      d = NOT_DIGIT;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = 5'(c - CH_ZERO);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         d = 5'(c - CH_LOWER_A) + 5'd10;
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         d = 5'(c - CH_UPPER_A) + 5'd10;
      end
      return d;
   endfunction

   // value times base, by shifts, with one add for decimal
   function automatic logic [PROD_WIDTH-1:0] scale_by_radix(
      input logic [VALUE_WIDTH-1:0] a,
      input radix_type              rk
   );
      logic [PROD_WIDTH-1:0] w;
      logic [PROD_WIDTH-1:0] s;
      w = PROD_WIDTH'(a);
      case (rk)
         RK_DEC:  s = (w << 3) + (w << 1);
         RK_HEX:  s = w << 4;
         RK_OCT:  s = w << 3;
         RK_BIN:  s = w << 1;
         default: s = w;
      endcase
      return s;
   endfunction

   function automatic logic digit_outside_base(
      input logic [4:0] d,
      input radix_type  rk
   );
      logic bad;
      case (rk)
         RK_DEC:  bad = (d > 5'd9);
         RK_HEX:  bad = 1'b0;
         RK_OCT:  bad = (d > 5'd7);
         RK_BIN:  bad = (d > 5'd1);
         default: bad = 1'b0;
      endcase
      return bad;
   endfunction

endpackage

### sv/ilsc_input_stage.sv
module ilsc_input_stage
   import ilsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   input  logic         item_taken,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   assign req_ready = !valid_ff || item_taken;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (item_taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### sv/ilsc_scan_unit.sv
module ilsc_scan_unit
   import ilsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   input  req_item_type    item,
   input  logic            out_free,
   output logic            item_taken,
   output logic            emit,
   output scan_result_type result
);

   phase_type              phase_ff,      phase_in;
   radix_type              radix_ff,      radix_in;
   logic [VALUE_WIDTH-1:0] accum_ff,      accum_in;
   logic                   overflowed_ff, overflowed_in;
   logic                   range_bad_ff,  range_bad_in;

   logic [4:0]             d;
   logic                   is_dec;
   logic                   is_hex;
   radix_type              add_radix;
   logic [PROD_WIDTH-1:0]  sum;
   logic                   sum_ovf;
   logic                   add_range_bad;
   logic                   emit_c;

   assign d      = digit_of(item.ch);
   assign is_dec = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
   assign is_hex = !d[4];

   // leading zero then decimal digit switches to octal
   assign add_radix = (phase_ff == PH_ZERO && is_dec) ? RK_OCT : radix_ff;

   assign sum           = scale_by_radix(accum_ff, add_radix) + PROD_WIDTH'(d);
   assign sum_ovf       = |sum[PROD_WIDTH-1:VALUE_WIDTH];
   assign add_range_bad = digit_outside_base(d, add_radix);

   always_comb begin
      phase_in      = phase_ff;
      radix_in      = radix_ff;
      accum_in      = accum_ff;
      overflowed_in = overflowed_ff;
      range_bad_in  = range_bad_ff;
      emit_c        = 1'b0;
      result.value      = '0;
      result.radix_kind = RK_DEC;
      result.error_code = ERR_NONE;
      if (item.first) begin
         radix_in      = RK_DEC;
         accum_in      = '0;
         overflowed_in = 1'b0;
         range_bad_in  = 1'b0;
         if (item.ch == CH_ZERO) begin
            phase_in = PH_ZERO;
         end else if (is_dec) begin
            accum_in = VALUE_WIDTH'(d);
            phase_in = PH_DIGITS;
         end else begin
            emit_c            = 1'b1;
            phase_in          = PH_IDLE;
            result.error_code = ERR_BAD_START;
         end
      end else begin
         case (phase_ff)
            PH_ZERO: begin
               if (item.ch == CH_LOWER_X || item.ch == CH_UPPER_X) begin
                  radix_in = RK_HEX;
                  phase_in = PH_DIGITS;
               end else if (item.ch == CH_LOWER_B || item.ch == CH_UPPER_B) begin
                  radix_in = RK_BIN;
                  phase_in = PH_DIGITS;
               end else if (is_hex) begin
                  radix_in = add_radix;
                  phase_in = PH_DIGITS;
                  if (add_range_bad) begin
                     range_bad_in = 1'b1;
                  end
                  if (sum_ovf) begin
                     overflowed_in = 1'b1;
                  end else begin
                     accum_in = sum[VALUE_WIDTH-1:0];
                  end
               end else begin
                  emit_c   = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            PH_DIGITS: begin
               if (is_hex) begin
                  if (add_range_bad) begin
                     range_bad_in = 1'b1;
                  end
                  if (!overflowed_ff) begin
                     if (sum_ovf) begin
                        overflowed_in = 1'b1;
                     end else begin
                        accum_in = sum[VALUE_WIDTH-1:0];
                     end
                  end
               end else begin
                  emit_c            = 1'b1;
                  phase_in          = PH_IDLE;
                  result.value      = accum_ff;
                  result.radix_kind = radix_ff;
                  if (overflowed_ff) begin
                     result.error_code = ERR_OVERFLOW;
                  end else if (range_bad_ff) begin
                     result.error_code = ERR_RANGE;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // hold the word only when it has a result and the output is still full
   assign item_taken = item_valid && (out_free || !emit_c);
   assign emit       = item_taken && emit_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         radix_ff      <= RK_DEC;
         accum_ff      <= '0;
         overflowed_ff <= 1'b0;
         range_bad_ff  <= 1'b0;
      end else if (item_taken) begin
         phase_ff      <= phase_in;
         radix_ff      <= radix_in;
         accum_ff      <= accum_in;
         overflowed_ff <= overflowed_in;
         range_bad_ff  <= range_bad_in;
      end
   end

endmodule

### sv/ilsc_output_stage.sv
module ilsc_output_stage
   import ilsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            emit,
   input  scan_result_type result,
   output logic            out_free,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output scan_result_type rsp_result
);

   logic            valid_ff;
   logic            valid_in;
   scan_result_type result_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

### sv/integer_literal_scanner_core.sv
// Scans unsigned integer literals one character word at a time. A word with
// req_first high starts a literal; 0x/0X gives hex, 0b/0B binary, a leading 0
// then a digit octal, other leading digits decimal. The first non-digit ends the
// literal and yields one response word with the value, radix and error code.
// A word can be taken every cycle while the scan stage does not stall; a
// request passes the input register and then the response register. The scan
// stage stalls only when a literal ends while the response register is full.
module integer_literal_scanner_core
   import ilsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_ch,
   input  logic                   req_first,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0] rsp_value,
   output logic [1:0]             rsp_radix_kind,
   output logic [1:0]             rsp_error_code
);

   req_item_type    req_item;
   req_item_type    item;
   logic            item_valid;
   logic            item_taken;
   logic            out_free;
   logic            emit;
   scan_result_type result;
   scan_result_type rsp_result;

   assign req_item.ch    = req_ch;
   assign req_item.first = req_first;

   ilsc_input_stage u_input_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_taken (item_taken),
      .item_valid (item_valid),
      .item       (item)
   );

   ilsc_scan_unit u_scan_unit (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .item_taken (item_taken),
      .emit       (emit),
      .result     (result)
   );

   ilsc_output_stage u_output_stage (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_value      = rsp_result.value;
   assign rsp_radix_kind = rsp_result.radix_kind;
   assign rsp_error_code = rsp_result.error_code;

endmodule
